// ===== rtl/mmgn_pkg.sv =====
// ----------------------------------------------------------------------------
// mmgn_pkg
// shared constants for the min-max grey normalizer: default sizes, request
// kinds and the grey scale
// ----------------------------------------------------------------------------
package mmgn_pkg;

	// default store depth and sample width
	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int SAMPLE_BITS_DEF = 16;

	// grey scale: 8-bit levels, full scale 255
	localparam int GREY_BITS = 8;
	localparam int GREY_MAX  = 255;

	// request kinds carried in tuser
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

endpackage

// ===== rtl/min_max_grey_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// min_max_grey_normalizer_core
// stores a frame of signed samples, tracks its minimum and maximum and turns
// a stored sample into an 8-bit grey level by min-max normalization
// ----------------------------------------------------------------------------
// A load request writes the sample to the on-chip store and updates the frame
// extremes without leaving idle; a load flagged first restarts the frame, and
// loads beyond MAX_SAMPLES are dropped. A read request returns
// round(255*(v-min)/(max-min)) with half-up rounding and occupies the block
// from accept to the next accept: one store read, the offset and range, the
// numerator, a bit-serial restoring divider that produces one quotient bit per
// cycle, and a step that hands the result to the output register. A read of an
// index not yet written, or of a flat frame, skips the divider. The result
// register lets the next request be taken while a result waits on m_tready.
module min_max_grey_normalizer_core #(
	parameter int MAX_SAMPLES = mmgn_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = mmgn_pkg::SAMPLE_BITS_DEF,
	parameter int IDX_BITS    = $clog2(MAX_SAMPLES),
	parameter int IN_BITS     = ((SAMPLE_BITS + IDX_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_BITS-1:0]              s_tdata,  // sample_value, read_index
	input  logic [1:0]                      s_tuser,  // req_type, first_sample
	// result channel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mmgn_pkg::GREY_BITS-1:0]  m_tdata,  // grey_level
	output logic                            m_tuser   // index_valid
);

	localparam int CNT_BITS  = $clog2(MAX_SAMPLES + 1);
	localparam int GB        = mmgn_pkg::GREY_BITS;
	localparam int STEP_BITS = $clog2(GB);
	localparam int NUM_BITS  = SAMPLE_BITS + GB + 1;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_NUM  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]               state_q;
	logic [CNT_BITS-1:0]      count_q;
	logic [SAMPLE_BITS-1:0]   lo_q;
	logic [SAMPLE_BITS-1:0]   hi_q;
	logic [SAMPLE_BITS-1:0]   store_mem [MAX_SAMPLES];
	logic [SAMPLE_BITS-1:0]   rd_data_q;
	logic                     rd_valid_q;
	logic [SAMPLE_BITS-1:0]   off_q;
	logic [SAMPLE_BITS-1:0]   range_q;
	logic [SAMPLE_BITS:0]     den_q;
	logic [SAMPLE_BITS:0]     rem_q;
	logic [GB-1:0]            quo_q;
	logic [STEP_BITS-1:0]     step_q;
	logic                     m_tvalid_q;
	logic [GB-1:0]            grey_q;
	logic                     idx_ok_q;

	logic                     req_kind;
	logic                     first_flag;
	logic [SAMPLE_BITS-1:0]   s_sample;
	logic [IDX_BITS-1:0]      s_index;
	logic                     accept;
	logic                     load_en;
	logic                     read_en;
	logic [CNT_BITS-1:0]      wr_ptr;
	logic                     store_full;
	logic [SAMPLE_BITS:0]     off_wide;
	logic [SAMPLE_BITS:0]     range_wide;
	logic [NUM_BITS-1:0]      numer;
	logic [SAMPLE_BITS+1:0]   trial;
	logic [SAMPLE_BITS+1:0]   trial_diff;
	logic                     qbit;

	// request fields
	assign req_kind   = s_tuser[0];
	assign first_flag = s_tuser[1];
	assign s_sample   = s_tdata[SAMPLE_BITS-1:0];
	assign s_index    = s_tdata[SAMPLE_BITS +: IDX_BITS];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// load pointer: a first load restarts at zero, a full store drops the load
	assign wr_ptr     = first_flag ? '0 : count_q;
	assign store_full = (wr_ptr == CNT_BITS'(MAX_SAMPLES));
	assign load_en    = accept && (req_kind == mmgn_pkg::REQ_LOAD) && !store_full;
	assign read_en    = accept && (req_kind == mmgn_pkg::REQ_READ);

	// offset and range, sign-extended differences that are never negative
	assign off_wide   = {rd_data_q[SAMPLE_BITS-1], rd_data_q} - {lo_q[SAMPLE_BITS-1], lo_q};
	assign range_wide = {hi_q[SAMPLE_BITS-1], hi_q} - {lo_q[SAMPLE_BITS-1], lo_q};

	// numerator 510*off + range for half-up rounding
	assign numer = ({off_q, 9'b0} - {8'b0, off_q, 1'b0}) + {9'b0, range_q};

	// one restoring division step
	assign trial      = {rem_q, quo_q[GB-1]};
	assign trial_diff = trial - {1'b0, den_q};
	assign qbit       = !trial_diff[SAMPLE_BITS+1];

	// sample store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (load_en) begin
			store_mem[wr_ptr[IDX_BITS-1:0]] <= s_sample;
		end
		if (read_en) begin
			rd_data_q <= store_mem[s_index];
		end
	end

	// frame count and extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
		end else if (load_en) begin
			count_q <= wr_ptr + CNT_BITS'(1);
			if (wr_ptr == '0) begin
				lo_q <= s_sample;
				hi_q <= s_sample;
			end else begin
				if ($signed(s_sample) < $signed(lo_q)) begin
					lo_q <= s_sample;
				end
				if ($signed(s_sample) > $signed(hi_q)) begin
					hi_q <= s_sample;
				end
			end
		end
	end

	// read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (read_en) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (!rd_valid_q || (range_wide == '0)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					state_q <= ST_DIV;
					step_q  <= STEP_BITS'(GB - 1);
				end
				ST_DIV: begin
					step_q <= step_q - STEP_BITS'(1);
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath of the read: index check, operands, serial divider
	always_ff @(posedge clk) begin
		if (read_en) begin
			rd_valid_q <= (CNT_BITS'(s_index) < count_q);
		end
		case (state_q)
			ST_PREP: begin
				off_q   <= off_wide[SAMPLE_BITS-1:0];
				range_q <= range_wide[SAMPLE_BITS-1:0];
				quo_q   <= '0;
			end
			ST_NUM: begin
				rem_q <= numer[NUM_BITS-1:GB];
				quo_q <= numer[GB-1:0];
				den_q <= {range_q, 1'b0};
			end
			ST_DIV: begin
				rem_q <= qbit ? trial_diff[SAMPLE_BITS:0] : trial[SAMPLE_BITS:0];
				quo_q <= {quo_q[GB-2:0], qbit};
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
			grey_q   <= quo_q;
			idx_ok_q <= rd_valid_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = grey_q;
	assign m_tuser  = idx_ok_q;

`ifndef SYNTHESIS
	// the frame never holds more samples than the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_SAMPLES))
		else $error("sample count beyond store depth");

	// extremes stay ordered while a frame holds samples
	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> ($signed(lo_q) <= $signed(hi_q)))
		else $error("frame minimum above maximum");

	// divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ({1'b0, rem_q} < {1'b0, den_q}))
		else $error("divider remainder out of range");

	// an unwritten index always reads as grey zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("invalid index gave a nonzero grey level");

	// a read request starts the sequencer on the next cycle
	a_read_start: assert property (@(posedge clk) disable iff (!arst_n)
		read_en |=> (state_q == ST_PREP))
		else $error("read request did not start the sequencer");
`endif

endmodule
